// ===== rtl/mwsm_pkg.sv =====
// Shared types and constants for the multiword schoolbook multiplier.
// Holds action codes, the controller command and datapath status structs.
// No dependencies.
package mwsm_pkg;

	localparam int WORD_BITS     = 32;
	localparam int IDX_BITS      = 6;
	localparam int DEF_MAX_WORDS = 16;

	localparam logic [1:0] ACT_LOAD_A   = 2'd0;
	localparam logic [1:0] ACT_LOAD_B   = 2'd1;
	localparam logic [1:0] ACT_MULTIPLY = 2'd2;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic clr_cnt;
		logic zero_out;
		logic start_mul;
		logic rd;
		logic mul;
		logic acc;
		logic row_end;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic a_empty;
		logic b_empty;
		logic j_last;
		logic i_last;
		logic k_last;
	} sts_t;

endpackage

// ===== rtl/multiword_schoolbook_multiplier.sv =====
// Top level of the multiword schoolbook multiplier.
// Joins controller mwsm_ctrl and datapath mwsm_dp; depends on mwsm_pkg.
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------
// item in  | start & !busy        | action, operand_word
// result   | strobe (one cycle)   | product_word, word_index, last_word
//
// Loads leave busy low. A multiply of n by t words runs read, multiply and
// accumulate steps per word pair (one shared 32x32 multiplier, one product
// memory with a read and a write port), a row-end step per row and an emit
// step per product word; words leave one per cycle, each registered from its read.
// An empty operand gives a single zero word in the cycle after the item.
// arst_n clears counts and control; memories hold no reset value.
// The receiver cannot stall: each strobe is taken in its own cycle.
module multiword_schoolbook_multiplier #(
	parameter int MAX_WORDS = mwsm_pkg::DEF_MAX_WORDS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [1:0]                        action,
	input  logic [mwsm_pkg::WORD_BITS-1:0]    operand_word,
	output logic                              busy,
	output logic                              strobe,
	output logic [mwsm_pkg::WORD_BITS-1:0]    product_word,
	output logic [mwsm_pkg::IDX_BITS-1:0]     word_index,
	output logic                              last_word
);
	import mwsm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mwsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	mwsm_dp #(
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operand_word (operand_word),
		.sts          (sts),
		.strobe       (strobe),
		.product_word (product_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

endmodule

// ===== rtl/mwsm_ctrl.sv =====
// Controller state machine of the multiword schoolbook multiplier.
// Sequences loads, the zero word for an empty operand, the row-by-row multiply-accumulate and product emission.
// Depends on mwsm_pkg.
module mwsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  mwsm_pkg::sts_t    sts,
	output mwsm_pkg::cmd_t    cmd,
	output logic              busy
);
	import mwsm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_RD     = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_ACC    = 6'b001000,
		ST_ROWEND = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_LOAD_A: cmd.load_a = 1'b1;
						ACT_LOAD_B: cmd.load_b = 1'b1;
						ACT_MULTIPLY: begin
							if (sts.a_empty || sts.b_empty) begin
								cmd.zero_out = 1'b1;
								cmd.clr_cnt  = 1'b1;
							end else begin
								cmd.start_mul = 1'b1;
								state_d       = ST_RD;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.j_last ? ST_ROWEND : ST_RD;
			end
			ST_ROWEND: begin
				cmd.row_end = 1'b1;
				state_d     = sts.i_last ? ST_EMIT : ST_RD;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.k_last) begin
					cmd.clr_cnt = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/mwsm_dp.sv =====
// Datapath of the multiword schoolbook multiplier.
// Holds operand and product memories, loop counters, multiplier and accumulator.
// Depends on mwsm_pkg; driven by mwsm_ctrl commands.
module mwsm_dp #(
	parameter int MAX_WORDS = mwsm_pkg::DEF_MAX_WORDS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mwsm_pkg::cmd_t                    cmd,
	input  logic [mwsm_pkg::WORD_BITS-1:0]    operand_word,
	output mwsm_pkg::sts_t                    sts,
	output logic                              strobe,
	output logic [mwsm_pkg::WORD_BITS-1:0]    product_word,
	output logic [mwsm_pkg::IDX_BITS-1:0]     word_index,
	output logic                              last_word
);
	import mwsm_pkg::*;

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int PD = 2 * MAX_WORDS;
	localparam int PW = $clog2(PD);
	localparam int TW = CW + 1;
	localparam int DW = 2 * WORD_BITS;

	logic [WORD_BITS-1:0] a_mem [MAX_WORDS];
	logic [WORD_BITS-1:0] b_mem [MAX_WORDS];
	logic [WORD_BITS-1:0] p_mem [PD];

	logic [CW-1:0]        a_cnt_q, b_cnt_q;
	logic [AW-1:0]        i_q, j_q;
	logic [PW-1:0]        k_q;
	logic [WORD_BITS-1:0] a_rd_q, b_rd_q, p_rd_q;
	logic [DW-1:0]        mul_q;
	logic [WORD_BITS-1:0] carry_q;
	logic                 strobe_q, last_q, zero_q;
	logic [PW-1:0]        idx_q;

	logic                 a_full, b_full;
	logic [PW-1:0]        pa_mac, pa_row, p_raddr, p_waddr;
	logic [WORD_BITS-1:0] p_in, p_wdata;
	logic [DW-1:0]        sum;
	logic [TW-1:0]        total;

	assign a_full  = (a_cnt_q == CW'(MAX_WORDS));
	assign b_full  = (b_cnt_q == CW'(MAX_WORDS));
	assign pa_mac  = PW'(i_q) + PW'(j_q);
	assign pa_row  = PW'(i_q) + PW'(b_cnt_q);
	assign p_raddr = cmd.emit ? k_q : pa_mac;
	assign p_in    = (i_q == '0) ? '0 : p_rd_q;
	assign sum     = mul_q + DW'(p_in) + DW'(carry_q);
	assign p_waddr = cmd.row_end ? pa_row : pa_mac;
	assign p_wdata = cmd.row_end ? carry_q : sum[WORD_BITS-1:0];
	assign total   = TW'(a_cnt_q) + TW'(b_cnt_q);

	assign sts.a_empty = (a_cnt_q == '0);
	assign sts.b_empty = (b_cnt_q == '0);
	assign sts.j_last  = (CW'(j_q) + 1'b1 == b_cnt_q);
	assign sts.i_last  = (CW'(i_q) + 1'b1 == a_cnt_q);
	assign sts.k_last  = (TW'(k_q) + 1'b1 == total);

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_a && !a_full) begin
			a_mem[a_cnt_q[AW-1:0]] <= operand_word;
		end
		if (cmd.load_b && !b_full) begin
			b_mem[b_cnt_q[AW-1:0]] <= operand_word;
		end
		if (cmd.acc || cmd.row_end) begin
			p_mem[p_waddr] <= p_wdata;
		end
		if (cmd.rd) begin
			a_rd_q <= a_mem[i_q];
			b_rd_q <= b_mem[j_q];
		end
		if (cmd.rd || cmd.emit) begin
			p_rd_q <= p_mem[p_raddr];
		end
		if (cmd.mul) begin
			mul_q <= DW'(a_rd_q) * DW'(b_rd_q);
		end
		if (cmd.emit || cmd.zero_out) begin
			idx_q  <= cmd.emit ? k_q : '0;
			last_q <= cmd.emit ? sts.k_last : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q  <= '0;
			b_cnt_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			carry_q  <= '0;
			strobe_q <= 1'b0;
			zero_q   <= 1'b0;
		end else begin
			if (cmd.clr_cnt) begin
				a_cnt_q <= '0;
				b_cnt_q <= '0;
			end else begin
				if (cmd.load_a && !a_full) a_cnt_q <= a_cnt_q + 1'b1;
				if (cmd.load_b && !b_full) b_cnt_q <= b_cnt_q + 1'b1;
			end
			if (cmd.start_mul) begin
				i_q     <= '0;
				j_q     <= '0;
				k_q     <= '0;
				carry_q <= '0;
			end
			if (cmd.acc) begin
				carry_q <= sum[DW-1:WORD_BITS];
				j_q     <= j_q + 1'b1;
			end
			if (cmd.row_end) begin
				carry_q <= '0;
				j_q     <= '0;
				i_q     <= i_q + 1'b1;
			end
			if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
			strobe_q <= cmd.emit || cmd.zero_out;
			if (cmd.emit || cmd.zero_out) begin
				zero_q <= cmd.zero_out;
			end
		end
	end

	assign strobe       = strobe_q;
	assign product_word = zero_q ? '0 : p_rd_q;
	assign word_index   = IDX_BITS'(idx_q);
	assign last_word    = last_q;

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("product words not back to back");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> idx_q == $past(idx_q) + 1'b1)
		else $error("product word index skipped");

	a_mac_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (CW'(j_q) < b_cnt_q) && (CW'(i_q) < a_cnt_q))
		else $error("accumulate outside loaded operands");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> (a_cnt_q == '0) && (b_cnt_q == '0))
		else $error("operands not cleared at end of run");

endmodule
